>>> design/tsrm_pkg.sv
// Package for the three-shear rotation mapper.
// Holds the fixed-point constants, field widths and register index codes.
// No dependencies; compile this file first.
package tsrm_pkg;

   // Largest source side and fraction bits of the trigonometric registers.
   localparam int MAX_SIDE  = 1024;
   localparam int FRAC_BITS = 16;
   localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

   // Widths of the request and response fields.
   localparam int POS_W   = 10;
   localparam int PIXEL_W = 24;
   localparam int DROW_W  = 11;
   localparam int INDEX_W = 22;

   // Widths of the configuration registers.
   localparam int TAN_W  = 24;
   localparam int SIN_W  = 18;
   localparam int SSIZE_W = 11;
   localparam int DSIZE_W = 12;

   // Configuration port.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;

   // Number of register stages from request to response register.
   localparam int PIPE_DEPTH = 14;

   typedef enum logic [2:0] {
      REG_TAN_HALF   = 3'd0,
      REG_SIN        = 3'd1,
      REG_SRC_WIDTH  = 3'd2,
      REG_SRC_HEIGHT = 3'd3,
      REG_DST_WIDTH  = 3'd4,
      REG_DST_HEIGHT = 3'd5,
      REG_BYPASS     = 3'd6
   } csr_index_type;

endpackage

>>> design/tsrm_req_if.sv
// Request channel of the three-shear rotation mapper: valid/ready plus payload.
// Depends on tsrm_pkg for the field widths.
interface tsrm_req_if import tsrm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [POS_W-1:0]   src_row;
   logic [POS_W-1:0]   src_col;
   logic [PIXEL_W-1:0] pixel;

   modport source (output valid, output src_row, output src_col, output pixel,
                   input ready);
   modport sink (input valid, input src_row, input src_col, input pixel,
                 output ready);
endinterface

>>> design/tsrm_rsp_if.sv
// Response channel of the three-shear rotation mapper: valid/ready plus payload.
// Depends on tsrm_pkg for the field widths.
interface tsrm_rsp_if import tsrm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [DROW_W-1:0]  dst_row;
   logic [DROW_W-1:0]  dst_col;
   logic [INDEX_W-1:0] dst_index;
   logic               in_bounds;
   logic [PIXEL_W-1:0] pixel_out;

   modport source (output valid, output dst_row, output dst_col, output dst_index,
                   output in_bounds, output pixel_out, input ready);
   modport sink (input valid, input dst_row, input dst_col, input dst_index,
                 input in_bounds, input pixel_out, output ready);
endinterface

>>> design/three_shear_rotation_mapper.sv
// Three-shear rotation mapper, top level.
// Depends on tsrm_pkg, tsrm_req_if and tsrm_rsp_if.
//
// Each request carries a source row, column and pixel. The block rotates the
// position about the image centre by an x shear (tan of half the angle), a y
// shear (sin of the angle) and the x shear again, re-centres it on the
// destination and returns row, column, linear index, an in-bounds flag and
// the unchanged pixel. Positions outside the destination come back with
// in_bounds low and zero coordinates. With bypass set, each pixel keeps its
// source position and is checked against the source size.
// The angle terms and image sizes are written through the APB port; the user
// must write them only while no request is in flight, which the block does not
// enforce. Reset loads bypass mode with 1024 x 1024 images. Throughput is one
// request per cycle, through fourteen register stages: centering, three shears
// of a multiply, an add and a rounding stage each, re-centering, the bounds
// check, the index multiply and the response register. All stages advance
// together: while a response waits for rsp.ready, req.ready is low and the
// pipeline holds; nothing is dropped or repeated. Reset empties the pipeline.
module three_shear_rotation_mapper import tsrm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   tsrm_req_if.sink              req,
   tsrm_rsp_if.source            rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // Configuration registers.
   logic signed [TAN_W-1:0] tan_ff;
   logic signed [SIN_W-1:0] sin_ff;
   logic [SSIZE_W-1:0]      src_width_ff;
   logic [SSIZE_W-1:0]      src_height_ff;
   logic [DSIZE_W-1:0]      dst_width_ff;
   logic [DSIZE_W-1:0]      dst_height_ff;
   logic                    bypass_ff;
   csr_index_type           csr_index;

   // Effective image sizes after saturation.
   logic [SSIZE_W-1:0] sw_sat;
   logic [SSIZE_W-1:0] sh_sat;
   logic [DSIZE_W-1:0] dw_sat;
   logic [DSIZE_W-1:0] dh_sat;
   logic [DSIZE_W-1:0] dw_eff;
   logic [DSIZE_W-1:0] dh_eff;

   logic adv;
   logic valid_ff [1:PIPE_DEPTH];

   // Position and pixel travel alongside the arithmetic.
   logic [POS_W-1:0]   row_ff [1:10];
   logic [POS_W-1:0]   col_ff [1:10];
   logic [PIXEL_W-1:0] pix_ff [1:13];

   // Datapath stages.
   logic signed [11:0] y1_ff, x1_ff;
   logic signed [35:0] m1_in, m1_ff;
   logic signed [11:0] x2_ff, y2_ff, y3_ff, y4_ff, y5_ff;
   logic signed [36:0] d1_in, d1_ff, r1;
   logic signed [19:0] nx1_in, nx1_4_ff, nx1_5_ff, nx1_6_ff, nx1_7_ff, nx1_8_ff;
   logic signed [37:0] m2_in, m2_ff;
   logic signed [38:0] d2_in, d2_ff, r2;
   logic signed [20:0] ny_in, ny7_ff, ny8_ff, ny9_ff, ny10_ff;
   logic signed [44:0] m3_in, m3_ff;
   logic signed [45:0] d3_in, d3_ff, r3;
   logic signed [27:0] nx_in, nx10_ff;
   logic signed [21:0] nr_in, nr11_ff;
   logic signed [28:0] nc_in, nc11_ff;
   logic               ok_in, ok12_ff, ok13_ff;
   logic [DROW_W-1:0]  r12_in, c12_in, r12_ff, c12_ff, r13_ff, c13_ff;
   logic [22:0]        prod13_ff;

   logic [DROW_W-1:0]  rsp_row_ff, rsp_col_ff;
   logic [INDEX_W-1:0] rsp_index_in, rsp_index_ff;
   logic               rsp_bounds_ff;
   logic [PIXEL_W-1:0] rsp_pixel_ff;

   // ---------------------------------------------------------------------
   // Configuration port
   // ---------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_index = csr_index_type'(paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         tan_ff        <= '0;
         sin_ff        <= '0;
         src_width_ff  <= SSIZE_W'(MAX_SIDE);
         src_height_ff <= SSIZE_W'(MAX_SIDE);
         dst_width_ff  <= DSIZE_W'(MAX_SIDE);
         dst_height_ff <= DSIZE_W'(MAX_SIDE);
         bypass_ff     <= 1'b1;
      end else if (psel && penable && pwrite && pready) begin
         case (csr_index)
            REG_TAN_HALF:   tan_ff        <= pwdata[TAN_W-1:0];
            REG_SIN:        sin_ff        <= pwdata[SIN_W-1:0];
            REG_SRC_WIDTH:  src_width_ff  <= pwdata[SSIZE_W-1:0];
            REG_SRC_HEIGHT: src_height_ff <= pwdata[SSIZE_W-1:0];
            REG_DST_WIDTH:  dst_width_ff  <= pwdata[DSIZE_W-1:0];
            REG_DST_HEIGHT: dst_height_ff <= pwdata[DSIZE_W-1:0];
            REG_BYPASS:     bypass_ff     <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      case (csr_index)
         REG_TAN_HALF:   prdata = {{(CSR_DATA_W-TAN_W){1'b0}}, tan_ff};
         REG_SIN:        prdata = {{(CSR_DATA_W-SIN_W){1'b0}}, sin_ff};
         REG_SRC_WIDTH:  prdata = {{(CSR_DATA_W-SSIZE_W){1'b0}}, src_width_ff};
         REG_SRC_HEIGHT: prdata = {{(CSR_DATA_W-SSIZE_W){1'b0}}, src_height_ff};
         REG_DST_WIDTH:  prdata = {{(CSR_DATA_W-DSIZE_W){1'b0}}, dst_width_ff};
         REG_DST_HEIGHT: prdata = {{(CSR_DATA_W-DSIZE_W){1'b0}}, dst_height_ff};
         REG_BYPASS:     prdata = {{(CSR_DATA_W-1){1'b0}}, bypass_ff};
         default:        prdata = '0;
      endcase
   end

   always_comb begin
      sw_sat = (src_width_ff  > SSIZE_W'(MAX_SIDE)) ? SSIZE_W'(MAX_SIDE) : src_width_ff;
      sh_sat = (src_height_ff > SSIZE_W'(MAX_SIDE)) ? SSIZE_W'(MAX_SIDE) : src_height_ff;
      dw_sat = (dst_width_ff  > DSIZE_W'(2 * MAX_SIDE)) ? DSIZE_W'(2 * MAX_SIDE)
                                                        : dst_width_ff;
      dh_sat = (dst_height_ff > DSIZE_W'(2 * MAX_SIDE)) ? DSIZE_W'(2 * MAX_SIDE)
                                                        : dst_height_ff;
      dw_eff = bypass_ff ? DSIZE_W'(sw_sat) : dw_sat;
      dh_eff = bypass_ff ? DSIZE_W'(sh_sat) : dh_sat;
   end

   // ---------------------------------------------------------------------
   // Pipeline control: every stage moves when the response register is free.
   // ---------------------------------------------------------------------
   assign adv       = !valid_ff[PIPE_DEPTH] || rsp.ready;
   assign req.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= PIPE_DEPTH; k++) valid_ff[k] <= 1'b0;
      end else if (adv) begin
         valid_ff[1] <= req.valid;
         for (int k = 2; k <= PIPE_DEPTH; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   // ---------------------------------------------------------------------
   // Datapath
   // ---------------------------------------------------------------------
   always_comb begin
      m1_in = y1_ff * tan_ff;
      d1_in = (37'(x2_ff) <<< FRAC_BITS) - 37'(m1_ff);
      // Adding half minus one on negative values and shifting arithmetically
      // rounds half away from zero.
      r1     = d1_ff + (d1_ff[36] ? 37'(ROUND_HALF - 1) : 37'(ROUND_HALF));
      nx1_in = 20'(r1 >>> FRAC_BITS);

      m2_in = nx1_4_ff * sin_ff;
      d2_in = 39'(m2_ff) + (39'(y5_ff) <<< FRAC_BITS);
      r2    = d2_ff + (d2_ff[38] ? 39'(ROUND_HALF - 1) : 39'(ROUND_HALF));
      ny_in = 21'(r2 >>> FRAC_BITS);

      m3_in = ny7_ff * tan_ff;
      d3_in = (46'(nx1_8_ff) <<< FRAC_BITS) - 46'(m3_ff);
      r3    = d3_ff + (d3_ff[45] ? 46'(ROUND_HALF - 1) : 46'(ROUND_HALF));
      nx_in = 28'(r3 >>> FRAC_BITS);

      // A negative result has its sign bit set, so it fails the bounds check
      // just as a value at or beyond the size does.
      if (bypass_ff) begin
         nr_in = $signed({12'b0, row_ff[10]});
         nc_in = $signed({19'b0, col_ff[10]});
      end else begin
         nr_in = $signed({11'b0, dh_sat[DSIZE_W-1:1]}) - 22'(ny10_ff);
         nc_in = $signed({18'b0, dw_sat[DSIZE_W-1:1]}) - 29'(nx10_ff);
      end

      ok_in = !nr11_ff[21] && !nc11_ff[28]
              && (nr11_ff[20:0] < 21'(dh_eff)) && (nc11_ff[27:0] < 28'(dw_eff));
      r12_in = ok_in ? nr11_ff[DROW_W-1:0] : '0;
      c12_in = ok_in ? nc11_ff[DROW_W-1:0] : '0;

      rsp_index_in = INDEX_W'(prod13_ff + 23'(c13_ff));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         row_ff[1] <= req.src_row;
         col_ff[1] <= req.src_col;
         pix_ff[1] <= req.pixel;
         for (int k = 2; k <= 10; k++) begin
            row_ff[k] <= row_ff[k-1];
            col_ff[k] <= col_ff[k-1];
         end
         for (int k = 2; k <= 13; k++) pix_ff[k] <= pix_ff[k-1];

         // Centering with flipped axes; x uses the same form on the width.
         y1_ff <= 12'($signed({2'b00, sh_sat}) - 13'sd1 - $signed({3'b000, req.src_row})
                      - $signed({3'b000, sh_sat[SSIZE_W-1:1]}));
         x1_ff <= 12'($signed({2'b00, sw_sat}) - 13'sd1 - $signed({3'b000, req.src_col})
                      - $signed({3'b000, sw_sat[SSIZE_W-1:1]}));

         m1_ff <= m1_in;
         x2_ff <= x1_ff;
         y2_ff <= y1_ff;

         d1_ff <= d1_in;
         y3_ff <= y2_ff;

         nx1_4_ff <= nx1_in;
         y4_ff    <= y3_ff;

         m2_ff    <= m2_in;
         nx1_5_ff <= nx1_4_ff;
         y5_ff    <= y4_ff;

         d2_ff    <= d2_in;
         nx1_6_ff <= nx1_5_ff;

         ny7_ff   <= ny_in;
         nx1_7_ff <= nx1_6_ff;

         m3_ff    <= m3_in;
         nx1_8_ff <= nx1_7_ff;
         ny8_ff   <= ny7_ff;

         d3_ff  <= d3_in;
         ny9_ff <= ny8_ff;

         nx10_ff <= nx_in;
         ny10_ff <= ny9_ff;

         nr11_ff <= nr_in;
         nc11_ff <= nc_in;

         ok12_ff <= ok_in;
         r12_ff  <= r12_in;
         c12_ff  <= c12_in;

         prod13_ff <= r12_ff * dw_eff;
         ok13_ff   <= ok12_ff;
         r13_ff    <= r12_ff;
         c13_ff    <= c12_ff;

         rsp_row_ff    <= r13_ff;
         rsp_col_ff    <= c13_ff;
         rsp_index_ff  <= rsp_index_in;
         rsp_bounds_ff <= ok13_ff;
         rsp_pixel_ff  <= pix_ff[13];
      end
   end

   assign rsp.valid     = valid_ff[PIPE_DEPTH];
   assign rsp.dst_row   = rsp_row_ff;
   assign rsp.dst_col   = rsp_col_ff;
   assign rsp.dst_index = rsp_index_ff;
   assign rsp.in_bounds = rsp_bounds_ff;
   assign rsp.pixel_out = rsp_pixel_ff;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the three-shear rotation mapper.
// Depends on tsrm_pkg, tsrm_req_if, tsrm_rsp_if and three_shear_rotation_mapper.
module testbench;
   import tsrm_pkg::*;

   localparam int  DRAIN_CYCLES = PIPE_DEPTH + 6;
   localparam int  CYCLE_LIMIT  = 500000;
   localparam real PI           = 3.14159265358979;

   typedef struct packed {
      logic [DROW_W-1:0]  row;
      logic [DROW_W-1:0]  col;
      logic [INDEX_W-1:0] index;
      logic               in_bounds;
      logic [PIXEL_W-1:0] pixel;
   } placement_type;

   logic clock = 1'b0;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   tsrm_req_if req_bus ();
   tsrm_rsp_if rsp_bus ();

   three_shear_rotation_mapper i_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Local copy of the mapping registers.
   logic signed [TAN_W-1:0] tan_half_cfg;
   logic signed [SIN_W-1:0] sin_cfg;
   logic [SSIZE_W-1:0]      src_w_cfg;
   logic [SSIZE_W-1:0]      src_h_cfg;
   logic [DSIZE_W-1:0]      dst_w_cfg;
   logic [DSIZE_W-1:0]      dst_h_cfg;
   logic                    bypass_cfg;

   placement_type pending_placements[$];
   int         mismatch_count = 0;
   int         cycle_count = 0;
   int         response_count = 0;
   logic       stalls_enabled;
   logic       sink_ready = 1'b0;
   int         stall_left = 0;

   assign rsp_bus.ready = sink_ready;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint round_half_away(input longint v);
      longint half;
      half = longint'(ROUND_HALF);
      if (v >= 0) return (v + half) >>> FRAC_BITS;
      else return -((-v + half) >>> FRAC_BITS);
   endfunction

   function automatic placement_type place_pixel(input logic [POS_W-1:0] row_in,
                                                 input logic [POS_W-1:0] col_in,
                                                 input logic [PIXEL_W-1:0] pix);
      longint one, sw, sh, dw, dh, y, x, nx, ny, nr, nc;
      placement_type p;
      one = longint'(1) << FRAC_BITS;
      sw = (src_w_cfg > MAX_SIDE) ? longint'(MAX_SIDE) : longint'(src_w_cfg);
      sh = (src_h_cfg > MAX_SIDE) ? longint'(MAX_SIDE) : longint'(src_h_cfg);
      if (bypass_cfg) begin
         dw = sw;
         dh = sh;
         nr = longint'(row_in);
         nc = longint'(col_in);
      end else begin
         dw = (dst_w_cfg > 2 * MAX_SIDE) ? longint'(2 * MAX_SIDE) : longint'(dst_w_cfg);
         dh = (dst_h_cfg > 2 * MAX_SIDE) ? longint'(2 * MAX_SIDE) : longint'(dst_h_cfg);
         y = sh - 1 - longint'(row_in) - sh / 2;
         x = sw - 1 - longint'(col_in) - sw / 2;
         nx = round_half_away(x * one - y * longint'(tan_half_cfg));
         ny = round_half_away(nx * longint'(sin_cfg) + y * one);
         nx = round_half_away(nx * one - ny * longint'(tan_half_cfg));
         nr = dh / 2 - ny;
         nc = dw / 2 - nx;
         // A negative position folds past the far edge, so it always lands outside.
         if (nr < 0) nr = dh - nr - 1;
         if (nc < 0) nc = dw - nc - 1;
      end
      p.pixel = pix;
      if (nr >= 0 && nc >= 0 && nr < dh && nc < dw) begin
         p.row       = DROW_W'(nr);
         p.col       = DROW_W'(nc);
         p.index     = INDEX_W'(nr * dw + nc);
         p.in_bounds = 1'b1;
      end else begin
         p.row       = '0;
         p.col       = '0;
         p.index     = '0;
         p.in_bounds = 1'b0;
      end
      return p;
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t ns, response %0d: %s", $time, response_count, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset || !stalls_enabled) begin
         stall_left = 0;
         sink_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         sink_ready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 14) - 1;
         sink_ready <= 1'b0;
      end else begin
         sink_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      placement_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_placements.size() == 0) begin
            report_mismatch("response arrived with no request outstanding");
         end else begin
            want = pending_placements.pop_front();
            if (rsp_bus.dst_row !== want.row)
               report_mismatch($sformatf("dst_row %0d, expected %0d",
                                         rsp_bus.dst_row, want.row));
            if (rsp_bus.dst_col !== want.col)
               report_mismatch($sformatf("dst_col %0d, expected %0d",
                                         rsp_bus.dst_col, want.col));
            if (rsp_bus.dst_index !== want.index)
               report_mismatch($sformatf("dst_index %0d, expected %0d",
                                         rsp_bus.dst_index, want.index));
            if (rsp_bus.in_bounds !== want.in_bounds)
               report_mismatch($sformatf("in_bounds %0b, expected %0b",
                                         rsp_bus.in_bounds, want.in_bounds));
            if (rsp_bus.pixel_out !== want.pixel)
               report_mismatch($sformatf("pixel_out %06h, expected %06h",
                                         rsp_bus.pixel_out, want.pixel));
         end
         response_count++;
      end
   end

   // Sends one request and records its expected placement once it is accepted.
   task automatic send_pixel(input int row, input int col, input int pix);
      if (stalls_enabled && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.src_row <= POS_W'(row);
      req_bus.src_col <= POS_W'(col);
      req_bus.pixel   <= PIXEL_W'(pix);
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_placements.push_back(place_pixel(POS_W'(row), POS_W'(col), PIXEL_W'(pix)));
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_placements.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Leaves psel high after the access cycle so that writes can follow back to back.
   task automatic write_register(input csr_index_type idx, input int value);
      logic [CSR_DATA_W-1:0] data;
      data = CSR_DATA_W'(value);
      case (idx)
         REG_TAN_HALF: begin
            data = data & 32'h00FF_FFFF;
            tan_half_cfg = data[TAN_W-1:0];
         end
         REG_SIN: begin
            data = data & 32'h0003_FFFF;
            sin_cfg = data[SIN_W-1:0];
         end
         REG_SRC_WIDTH: begin
            data = data & 32'h0000_07FF;
            src_w_cfg = data[SSIZE_W-1:0];
         end
         REG_SRC_HEIGHT: begin
            data = data & 32'h0000_07FF;
            src_h_cfg = data[SSIZE_W-1:0];
         end
         REG_DST_WIDTH: begin
            data = data & 32'h0000_0FFF;
            dst_w_cfg = data[DSIZE_W-1:0];
         end
         REG_DST_HEIGHT: begin
            data = data & 32'h0000_0FFF;
            dst_h_cfg = data[DSIZE_W-1:0];
         end
         REG_BYPASS: begin
            data = data & 32'h0000_0001;
            bypass_cfg = data[0];
         end
         default: ;
      endcase
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
   endtask

   task automatic set_mapping(input int tan_v, input int sin_v, input int sw, input int sh,
                              input int dw, input int dh, input int byp);
      wait_idle();
      write_register(REG_TAN_HALF, tan_v);
      write_register(REG_SIN, sin_v);
      write_register(REG_SRC_WIDTH, sw);
      write_register(REG_SRC_HEIGHT, sh);
      write_register(REG_DST_WIDTH, dw);
      write_register(REG_DST_HEIGHT, dh);
      write_register(REG_BYPASS, byp);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic int raw_size(input int bits);
      case ($urandom_range(0, 5))
         0: return 0;
         1: return (1 << bits) - 1;
         2: return $urandom_range(1, (1 << bits) - 1);
         default: return $urandom_range(1, 64);
      endcase
   endfunction

   // Mostly positions inside the source image, now and then anywhere in the field.
   function automatic int pick_position(input int side);
      int lim;
      lim = (side > MAX_SIDE) ? MAX_SIDE : side;
      if (lim != 0 && $urandom_range(0, 4) != 0) return $urandom_range(0, lim - 1);
      return $urandom_range(0, (1 << POS_W) - 1);
   endfunction

   // Settings as software would derive them from an angle in degrees.
   task automatic pick_rotation();
      real deg, rad, t, s, c, wr, hr;
      int  w, h;
      deg = $urandom_range(0, 35999) / 100.0;
      rad = -deg * PI / 180.0;
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_SIDE) : $urandom_range(1, 48);
      h = ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_SIDE) : $urandom_range(1, 48);
      t = $tan(rad / 2.0) * 65536.0;
      if (t > 8388607.0) t = 8388607.0;
      if (t < -8388608.0) t = -8388608.0;
      s = $sin(rad);
      c = $cos(rad);
      wr = (w * c < 0.0 ? -w * c : w * c) + (h * s < 0.0 ? -h * s : h * s);
      hr = (w * s < 0.0 ? -w * s : w * s) + (h * c < 0.0 ? -h * c : h * c);
      set_mapping(int'(t), int'(s * 65536.0), w, h, int'($ceil(wr)), int'($ceil(hr)),
                  (deg < 0.01 || deg > 359.99) ? 1 : 0);
   endtask

   task automatic test_bypass_identity();
      send_pixel(0, 0, 0);
      send_pixel(1023, 1023, 24'hFFFFFF);
      send_pixel(0, 1023, 24'hAAAAAA);
      send_pixel(1023, 0, 24'h555555);
   endtask

   task automatic test_bypass_bounds();
      set_mapping(0, 0, 5, 7, 1, 1, 1);
      send_pixel(6, 4, 24'h123456);
      send_pixel(7, 0, 24'h654321);
      send_pixel(0, 5, 24'hABCDEF);
      // A zero width puts everything outside; oversized heights clamp.
      set_mapping(0, 0, 0, 2047, 1, 1, 1);
      send_pixel(3, 0, 24'h0F0F0F);
      set_mapping(0, 0, 2047, 2047, 1, 1, 1);
      send_pixel(1023, 1023, 24'hF0F0F0);
   endtask

   task automatic test_shear_extremes();
      set_mapping(0, 0, 1024, 1024, 1024, 1024, 0);
      send_pixel(0, 0, 24'h000001);
      send_pixel(1023, 1023, 24'h800000);
      set_mapping(8388607, 65536, 1024, 1024, 4095, 4095, 0);
      send_pixel(0, 0, 24'h111111);
      send_pixel(1023, 1023, 24'h222222);
      send_pixel(512, 100, 24'h333333);
      set_mapping(-8388608, -65536, 1024, 1024, 2048, 2048, 0);
      send_pixel(0, 1023, 24'h444444);
      send_pixel(1023, 0, 24'h555555);
      // Sine beyond one is taken as written.
      set_mapping(0, 131071, 2047, 2047, 2048, 2048, 0);
      send_pixel(0, 0, 24'h666666);
      send_pixel(1023, 512, 24'h777777);
      set_mapping(0, -131072, 1024, 1024, 2048, 2048, 0);
      send_pixel(100, 900, 24'h888888);
      set_mapping(-65536, -65536, 9, 5, 0, 0, 0);
      send_pixel(4, 2, 24'h999999);
      // Quarter turn of an odd-sized image.
      set_mapping(-65536, -65536, 9, 5, 5, 9, 0);
      send_pixel(0, 0, 24'hAAAAAA);
      send_pixel(4, 8, 24'hBBBBBB);
      send_pixel(2, 3, 24'hCCCCCC);
      set_mapping(0, 0, 64, 64, 3, 3, 0);
      send_pixel(0, 0, 24'hDDDDDD);
      send_pixel(31, 31, 24'hEEEEEE);
   endtask

   task automatic test_random_rotations();
      int kind;
      for (int phase = 0; phase < 12; phase++) begin
         wait_idle();
         stalls_enabled <= (phase < 10) && (phase % 4 != 3);
         kind = (phase >= 10) ? 0 : phase % 3;
         case (kind)
            0: pick_rotation();
            1: set_mapping($urandom(), $urandom(), raw_size(SSIZE_W), raw_size(SSIZE_W),
                           raw_size(DSIZE_W), raw_size(DSIZE_W),
                           ($urandom_range(0, 3) == 0) ? 1 : 0);
            default: set_mapping($urandom(), $urandom(), raw_size(SSIZE_W),
                                 raw_size(SSIZE_W), raw_size(DSIZE_W),
                                 raw_size(DSIZE_W), 1);
         endcase
         for (int n = 0; n < 100; n++)
            send_pixel(pick_position(src_h_cfg), pick_position(src_w_cfg),
                       $urandom_range(0, (1 << PIXEL_W) - 1));
      end
   endtask

   initial begin
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.src_row <= '0;
      req_bus.src_col <= '0;
      req_bus.pixel   <= '0;
      psel            <= 1'b0;
      penable         <= 1'b0;
      pwrite          <= 1'b0;
      paddr           <= '0;
      pwdata          <= '0;
      stalls_enabled  <= 1'b1;
      tan_half_cfg = '0;
      sin_cfg      = '0;
      src_w_cfg    = SSIZE_W'(1024);
      src_h_cfg    = SSIZE_W'(1024);
      dst_w_cfg    = DSIZE_W'(1024);
      dst_h_cfg    = DSIZE_W'(1024);
      bypass_cfg   = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_bypass_identity();
      test_bypass_bounds();
      test_shear_extremes();
      test_random_rotations();
      wait_idle();
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
